// File: rtl/spd_pkg.sv
`default_nettype none

package spd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int PROD_W     = 34;
    localparam int SUM_W      = 35;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DELAY_W    = 17;

    localparam logic [GAIN_W-1:0]  DRY_RESET      = 16'd32768;
    localparam logic [GAIN_W-1:0]  WET_RESET      = 16'd32768;
    localparam logic [GAIN_W-1:0]  FEEDBACK_RESET = 16'd16384;
    localparam logic [GAIN_W-1:0]  WIDTH_RESET    = 16'd16384;
    localparam logic [DELAY_W-1:0] DELAY_RESET    = 17'd65536;
    localparam logic [GAIN_W-1:0]  Q_ONE          = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRY      = 3'd0,
        CFG_WET      = 3'd1,
        CFG_FEEDBACK = 3'd2,
        CFG_WIDTH    = 3'd3,
        CFG_DELAY    = 3'd4
    } t_cfg_idx;

    // left in the low half, matching the stream packing
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } t_frame;

    typedef struct packed {
        logic [GAIN_W-1:0] dry;
        logic [GAIN_W-1:0] wet;
        logic [GAIN_W-1:0] feedback;
        logic [GAIN_W-1:0] width;
        logic [GAIN_W-1:0] left_share;
    } t_gains;

    // unsigned gain times signed sample
    function automatic logic signed [PROD_W-1:0] mul_gain(
        input logic [GAIN_W-1:0]          g,
        input logic signed [SAMPLE_W-1:0] s
    );
        logic signed [GAIN_W:0]   a;
        logic signed [SAMPLE_W:0] b;
        a = $signed({1'b0, g});
        b = $signed({s[SAMPLE_W-1], s});
        return a * b;
    endfunction

    // floor((pa + pb + 2^14) / 2^15), saturated to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] pa,
        input logic signed [PROD_W-1:0] pb
    );
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] q;
        logic signed [SAMPLE_W-1:0] r;
        y = SUM_W'(pa) + SUM_W'(pb) + SUM_W'(16384);
        q = y >>> 15;
        if (q > SUM_W'(32767)) begin
            r = 16'sh7fff;
        end else if (q < -SUM_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/spd_ram.sv
`default_nettype none

module spd_ram #(
    parameter int DEPTH = 65536
) (
    input  logic                                i_clk,
    input  logic                                i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]            i_rd_addr,
    output spd_pkg::t_frame                     o_rd_data,
    input  logic                                i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]            i_wr_addr,
    input  spd_pkg::t_frame                     i_wr_data
);
    import spd_pkg::*;

    // both delay lines side by side, one frame per entry
    t_frame r_mem [DEPTH];
    t_frame r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/spd_mix.sv
`default_nettype none

module spd_mix (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  spd_pkg::t_gains                     i_gains,
    input  spd_pkg::t_frame                     i_frame,
    input  logic signed [spd_pkg::SAMPLE_W-1:0] i_mono,
    input  spd_pkg::t_frame                     i_delayed,
    output spd_pkg::t_frame                     o_out,
    output spd_pkg::t_frame                     o_line
);
    import spd_pkg::*;

    logic signed [PROD_W-1:0] r_p_dry_l;
    logic signed [PROD_W-1:0] r_p_wet_l;
    logic signed [PROD_W-1:0] r_p_dry_r;
    logic signed [PROD_W-1:0] r_p_wet_r;
    logic signed [PROD_W-1:0] r_p_mono_l;
    logic signed [PROD_W-1:0] r_p_fb_l;
    logic signed [PROD_W-1:0] r_p_mono_r;
    logic signed [PROD_W-1:0] r_p_fb_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_dry_l  <= mul_gain(i_gains.dry, i_frame.left);
            r_p_wet_l  <= mul_gain(i_gains.wet, i_delayed.left);
            r_p_dry_r  <= mul_gain(i_gains.dry, i_frame.right);
            r_p_wet_r  <= mul_gain(i_gains.wet, i_delayed.right);
            // cross feed: left line takes the delayed right sample and vice versa
            r_p_mono_l <= mul_gain(i_gains.left_share, i_mono);
            r_p_fb_l   <= mul_gain(i_gains.feedback, i_delayed.right);
            r_p_mono_r <= mul_gain(i_gains.width, i_mono);
            r_p_fb_r   <= mul_gain(i_gains.feedback, i_delayed.left);
        end
    end

    always_comb begin
        o_out.left   = round_sat(r_p_dry_l, r_p_wet_l);
        o_out.right  = round_sat(r_p_dry_r, r_p_wet_r);
        o_line.left  = round_sat(r_p_mono_l, r_p_fb_l);
        o_line.right = round_sat(r_p_mono_r, r_p_fb_r);
    end

endmodule

`default_nettype wire

// File: rtl/stereo_ping_pong_delay.sv
`default_nettype none

// Stereo ping-pong delay. One stereo frame enters on the s-side stream and one
// processed frame leaves on the m-side stream for each accepted transaction.
// Gains, stereo width and delay length are set through the register write
// port. Write them only while no frame is in flight; it is not enforced.
//
// An accepted frame is read from the RAM in stage 1, multiplied into the
// product registers, summed and written back, then held in the output buffer.
// No new frame is taken while one sits in stage 1, as set by the cross feedback
// loop; at a one-frame delay a line sample feeds the next frame's multipliers.
// Both delay lines sit in one synchronous RAM, one frame per entry.
//
// Reset clears the write pointer and loads the register defaults. The lines
// read back as zero until written, tracked by the write pointer and a wrap
// flag, so no clearing pass is run and the block is ready right after reset.
// A two-entry output buffer keeps taking frames while the receiver stalls;
// o_s_tready drops once in-flight frames would fill it.
module stereo_ping_pong_delay #(
    parameter int LINE_DEPTH = 65536
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [spd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [spd_pkg::FRAME_W-1:0]       i_s_tdata,   // left_in, right_in
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [spd_pkg::FRAME_W-1:0]       o_m_tdata    // left_out, right_out
);
    import spd_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = (AW + 1 > DELAY_W) ? AW + 1 : DELAY_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
    localparam logic [AW-1:0] LAST_WP = AW'(LINE_DEPTH - 1);

    // registers
    logic [GAIN_W-1:0]  r_dry;
    logic [GAIN_W-1:0]  r_wet;
    logic [GAIN_W-1:0]  r_feedback;
    logic [GAIN_W-1:0]  r_width;
    logic [DELAY_W-1:0] r_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry      <= DRY_RESET;
            r_wet      <= WET_RESET;
            r_feedback <= FEEDBACK_RESET;
            r_width    <= WIDTH_RESET;
            r_delay    <= DELAY_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DRY:      r_dry      <= i_cfg_data[GAIN_W-1:0];
                CFG_WET:      r_wet      <= i_cfg_data[GAIN_W-1:0];
                CFG_FEEDBACK: r_feedback <= i_cfg_data[GAIN_W-1:0];
                CFG_WIDTH:    r_width    <= i_cfg_data[GAIN_W-1:0];
                CFG_DELAY:    r_delay    <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    t_gains w_gains;

    always_comb begin
        w_gains.dry      = r_dry;
        w_gains.wet      = r_wet;
        w_gains.feedback = r_feedback;
        w_gains.width    = r_width;
        if (r_width >= Q_ONE) begin
            w_gains.left_share = '0;
        end else begin
            w_gains.left_share = Q_ONE - r_width;
        end
    end

    // pipeline control
    logic        r_s1_v;
    logic        r_s2_v;
    logic [1:0]  r_cnt;
    logic        w_accept;
    logic        w_push;
    logic        w_pop;

    assign o_s_tready = !r_s1_v && ((r_cnt == 2'd0) || (r_cnt == 2'd1 && !r_s2_v));
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_push     = r_s2_v;
    assign w_pop      = o_m_tvalid && i_m_tready;

    // write pointer and fill tracking
    logic [AW-1:0] r_wp;
    logic          r_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (w_accept) begin
            if (r_wp == LAST_WP) begin
                r_wp   <= '0;
                r_full <= 1'b1;
            end else begin
                r_wp <= r_wp + AW'(1);
            end
        end
    end

    // read position, delay clamped to 1..LINE_DEPTH
    logic [CW-1:0] w_d_raw;
    logic [CW-1:0] w_d;
    logic [CW-1:0] w_wp_ext;
    logic [CW-1:0] w_rp_ext;
    logic [AW-1:0] w_rp;

    always_comb begin
        w_d_raw  = CW'(r_delay);
        w_wp_ext = CW'(r_wp);
        if (w_d_raw == '0) begin
            w_d = CW'(1);
        end else if (w_d_raw > DEPTH_C) begin
            w_d = DEPTH_C;
        end else begin
            w_d = w_d_raw;
        end
        if (w_wp_ext >= w_d) begin
            w_rp_ext = w_wp_ext - w_d;
        end else begin
            w_rp_ext = w_wp_ext + DEPTH_C - w_d;
        end
        w_rp = w_rp_ext[AW-1:0];
    end

    // stage 1 payload
    t_frame                     r_s1_frame;
    logic signed [SAMPLE_W-1:0] r_s1_mono;
    logic [AW-1:0]              r_s1_wp;
    logic [AW-1:0]              r_s2_wp;
    logic                       r_fwd;
    t_frame                     r_fwd_data;
    logic                       r_rd_valid;
    logic signed [SAMPLE_W:0]   w_pair_sum;

    t_frame w_in_frame;
    t_frame w_rd_data;
    t_frame w_delayed;
    t_frame w_out;
    t_frame w_line;

    assign w_in_frame = i_s_tdata;
    assign w_pair_sum = {w_in_frame.left[SAMPLE_W-1], w_in_frame.left}
                        + {w_in_frame.right[SAMPLE_W-1], w_in_frame.right};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_frame <= w_in_frame;
            r_s1_mono  <= w_pair_sum[SAMPLE_W:1];
            r_s1_wp    <= r_wp;
            // the frame in stage 2 writes this very edge: take its value directly
            r_fwd      <= r_s2_v && (r_s2_wp == w_rp);
            r_fwd_data <= w_line;
            r_rd_valid <= r_full || (w_rp < r_wp);
        end
        r_s2_wp <= r_s1_wp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= w_accept;
            r_s2_v <= r_s1_v;
        end
    end

    always_comb begin
        if (r_fwd) begin
            w_delayed = r_fwd_data;
        end else if (r_rd_valid) begin
            w_delayed = w_rd_data;
        end else begin
            w_delayed = '0;
        end
    end

    spd_ram #(
        .DEPTH(LINE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rp),
        .o_rd_data (w_rd_data),
        .i_wr_en   (r_s2_v),
        .i_wr_addr (r_s2_wp),
        .i_wr_data (w_line)
    );

    spd_mix u_mix (
        .i_clk     (i_clk),
        .i_en      (r_s1_v),
        .i_gains   (w_gains),
        .i_frame   (r_s1_frame),
        .i_mono    (r_s1_mono),
        .i_delayed (w_delayed),
        .o_out     (w_out),
        .o_line    (w_line)
    );

    // two-entry output buffer
    t_frame r_q0;
    t_frame r_q1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_cnt == 2'd2) begin
                r_q0 <= r_q1;
                if (w_push) begin
                    r_q1 <= w_out;
                end
            end else if (w_push) begin
                r_q0 <= w_out;
            end
        end else if (w_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= w_out;
            end else begin
                r_q1 <= w_out;
            end
        end
    end

    assign o_m_tvalid = (r_cnt != 2'd0);
    assign o_m_tdata  = r_q0;

endmodule

`default_nettype wire
